### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is held.
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/obue_pkg.sv
// Shared types and constants of the order book update engine.
// No dependencies.
package obue_pkg;

  localparam int BOOK_DEPTH  = 1024;
  localparam int ADDR_W      = $clog2(BOOK_DEPTH);
  localparam int CNT_W       = $clog2(BOOK_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_STALE   = 3'd1;
  localparam logic [2:0] ST_GAP     = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic signed [47:0] SIZE_MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SIZE_MIN48 = 48'sh8000_0000_0000;

  typedef struct packed {
    logic               req_type;
    logic [62:0]        sequence_req;
    logic               has_bid;
    logic [63:0]        bid_order_id;
    logic [31:0]        bid_price;
    logic signed [47:0] bid_size;
    logic               has_ask;
    logic [63:0]        ask_order_id;
    logic [31:0]        ask_price;
    logic signed [47:0] ask_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [62:0]        out_sequence;
    logic               bid_valid;
    logic [63:0]        bid_out_order_id;
    logic [31:0]        bid_out_price;
    logic signed [47:0] bid_out_size;
    logic               ask_valid;
    logic [63:0]        ask_out_order_id;
    logic [31:0]        ask_out_price;
    logic signed [47:0] ask_out_size;
  } out_item_t;

  typedef struct packed {
    logic               has;
    logic [63:0]        oid;
    logic [31:0]        price;
    logic signed [47:0] size;
  } side_cmd_t;

  // Index 0 is the bid side, index 1 the ask side.
  typedef struct packed {
    logic             is_load;
    logic [62:0]      seq;
    side_cmd_t [1:0]  sd;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               side;
    logic [63:0]        oid;
    logic [31:0]        price;
    logic signed [47:0] size;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam int CMD_W  = $bits(cmd_t);

endpackage

### rtl/obue_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module obue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/obue_front.sv
// Front end: accepts input requests and classifies them into commands.
// Depends on obue_pkg.
module obue_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  obue_pkg::in_item_t in_data,
  output logic              q_push,
  input  logic              q_full,
  output obue_pkg::cmd_t    q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd          = '0;
    q_cmd.is_load  = (in_data.req_type == obue_pkg::REQ_LOAD);
    q_cmd.seq      = in_data.sequence_req;
    q_cmd.sd[0].has   = in_data.has_bid;
    q_cmd.sd[0].oid   = in_data.bid_order_id;
    q_cmd.sd[0].price = in_data.bid_price;
    q_cmd.sd[0].size  = in_data.bid_size;
    q_cmd.sd[1].has   = in_data.has_ask;
    q_cmd.sd[1].oid   = in_data.ask_order_id;
    q_cmd.sd[1].price = in_data.ask_price;
    q_cmd.sd[1].size  = in_data.ask_size;
  end

endmodule

### rtl/obue_queue.sv
// Short command queue between the front end and the book engine.
// Depends on obue_pkg.
module obue_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  obue_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output obue_pkg::cmd_t pop_cmd
);

  obue_pkg::cmd_t                     entry_r [obue_pkg::QUEUE_DEPTH];
  logic [obue_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [obue_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [obue_pkg::QCNT_W-1:0]        count_r;
  logic                               do_push;
  logic                               do_pop;

  assign full     = (count_r == obue_pkg::QCNT_W'(obue_pkg::QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign pop_cmd  = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        entry_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r <= (wr_ptr_r == obue_pkg::QPTR_W'(obue_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == obue_pkg::QPTR_W'(obue_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/obue_back.sv
// Book engine: sequence check, slot table scans, entry writes and result register.
// Depends on obue_pkg and obue_ram.
module obue_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nonempty,
  input  obue_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output obue_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SEQ, S_SIDE, S_LOOK, S_MATCH, S_APPLY, S_DONE
  } state_t;

  state_t                        state_r;
  obue_pkg::cmd_t                cmd_r;
  logic                          side_r;
  logic [2:0]                    status_r;
  logic [obue_pkg::CNT_W-1:0]    cnt_r;
  logic                          found_r;
  logic                          hit_r;
  logic [obue_pkg::ADDR_W-1:0]   hit_idx_r;
  logic signed [47:0]            hit_size_r;
  logic                          free_r;
  logic [obue_pkg::ADDR_W-1:0]   free_idx_r;
  logic [31:0]                   rprice_r;
  logic [1:0]                    res_valid_r;
  logic [1:0][31:0]              res_price_r;
  logic [1:0][47:0]              res_size_r;
  logic [62:0]                   last_seq_r;
  logic                          out_valid_r;
  obue_pkg::out_item_t           out_data_r;

  logic                          ram_we;
  logic [obue_pkg::ADDR_W-1:0]   ram_waddr;
  obue_pkg::slot_t               ram_wdata;
  logic [obue_pkg::SLOT_W-1:0]   ram_rdata;
  obue_pkg::slot_t               rd_slot;
  logic [obue_pkg::ADDR_W-1:0]   rd_idx;
  logic                          rd_ok;
  logic                          scan_end;

  obue_pkg::side_cmd_t           cur;
  logic signed [48:0]            sum;
  logic signed [47:0]            new_size;
  logic [2:0]                    apply_st;
  logic                          apply_wr;
  logic [obue_pkg::ADDR_W-1:0]   apply_addr;
  obue_pkg::slot_t               apply_slot;

  assign cur      = cmd_r.sd[side_r];
  assign rd_slot  = obue_pkg::slot_t'(ram_rdata);
  assign rd_idx   = obue_pkg::ADDR_W'(cnt_r - 1'b1);
  assign rd_ok    = (cnt_r != '0);
  assign scan_end = (cnt_r == obue_pkg::CNT_W'(obue_pkg::BOOK_DEPTH));
  assign q_pop    = (state_r == S_IDLE) && q_nonempty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  obue_ram #(
    .WIDTH (obue_pkg::SLOT_W),
    .DEPTH (obue_pkg::BOOK_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[obue_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Resolve the side's effect from the scan results.
  always_comb begin
    sum        = 49'(hit_size_r) + 49'(cur.size);
    new_size   = cur.size;
    apply_st   = obue_pkg::ST_OK;
    apply_wr   = 1'b0;
    apply_addr = free_idx_r;
    apply_slot = '{valid: 1'b1, side: side_r, oid: cur.oid, price: rprice_r,
                   size: cur.size};
    if (cmd_r.is_load) begin
      if (free_r) begin
        apply_wr = 1'b1;
      end else begin
        apply_st = obue_pkg::ST_FULL;
      end
    end else begin
      if (cur.size < 0) begin
        if (sum > 49'(obue_pkg::SIZE_MAX48)) begin
          new_size = obue_pkg::SIZE_MAX48;
        end else if (sum < 49'(obue_pkg::SIZE_MIN48)) begin
          new_size = obue_pkg::SIZE_MIN48;
        end else begin
          new_size = sum[47:0];
        end
      end
      apply_slot.size = new_size;
      if (cur.size < 0 && !hit_r) begin
        apply_st = obue_pkg::ST_MISSING;
      end else if (new_size != 0) begin
        if (hit_r) begin
          apply_wr   = 1'b1;
          apply_addr = hit_idx_r;
        end else if (free_r) begin
          apply_wr = 1'b1;
        end else begin
          apply_st = obue_pkg::ST_FULL;
        end
      end else if (hit_r) begin
        apply_wr         = 1'b1;
        apply_addr       = hit_idx_r;
        apply_slot.valid = 1'b0;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = apply_addr;
    ram_wdata = apply_slot;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[obue_pkg::ADDR_W-1:0];
        ram_wdata = '0;
      end
      S_APPLY: begin
        ram_we = apply_wr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      last_seq_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the result register is refilled below instead.
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (cnt_r == obue_pkg::CNT_W'(obue_pkg::BOOK_DEPTH - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_nonempty) begin
            cmd_r       <= q_cmd;
            side_r      <= 1'b0;
            status_r    <= obue_pkg::ST_OK;
            res_valid_r <= '0;
            res_price_r <= '0;
            res_size_r  <= '0;
            state_r     <= S_SEQ;
          end
        end
        S_SEQ: begin
          if (cmd_r.is_load) begin
            last_seq_r <= cmd_r.seq;
            state_r    <= S_SIDE;
          end else if (cmd_r.seq <= last_seq_r) begin
            status_r <= obue_pkg::ST_STALE;
            state_r  <= S_DONE;
          end else if (cmd_r.seq != last_seq_r + 1'b1) begin
            status_r <= obue_pkg::ST_GAP;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_SIDE;
          end
        end
        S_SIDE: begin
          cnt_r   <= '0;
          found_r <= 1'b0;
          hit_r   <= 1'b0;
          free_r  <= 1'b0;
          rprice_r <= cur.price;
          if (status_r != obue_pkg::ST_OK) begin
            state_r <= S_DONE;
          end else if (!cur.has) begin
            if (side_r) begin
              state_r <= S_DONE;
            end
            side_r <= 1'b1;
          end else if (cmd_r.is_load && cur.size == 0) begin
            // A zero-size snapshot entry is reported but never stored.
            res_valid_r[side_r] <= 1'b1;
            res_price_r[side_r] <= cur.price;
            if (side_r) begin
              state_r <= S_DONE;
            end
            side_r <= 1'b1;
          end else if (!cmd_r.is_load && cur.price == '0) begin
            state_r <= S_LOOK;
          end else begin
            state_r <= S_MATCH;
          end
        end
        S_LOOK: begin
          if (rd_ok && !found_r && rd_slot.valid && rd_slot.oid == cur.oid) begin
            found_r  <= 1'b1;
            rprice_r <= rd_slot.price;
          end
          if (scan_end) begin
            cnt_r <= '0;
            if (found_r || (rd_slot.valid && rd_slot.oid == cur.oid)) begin
              state_r <= S_MATCH;
            end else begin
              status_r <= obue_pkg::ST_UNKNOWN;
              state_r  <= S_DONE;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MATCH: begin
          if (rd_ok) begin
            if (!hit_r && !cmd_r.is_load && rd_slot.valid && rd_slot.side == side_r &&
                rd_slot.oid == cur.oid && rd_slot.price == rprice_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= rd_idx;
              hit_size_r <= rd_slot.size;
            end
            if (!free_r && !rd_slot.valid) begin
              free_r     <= 1'b1;
              free_idx_r <= rd_idx;
            end
          end
          if (scan_end) begin
            state_r <= S_APPLY;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_APPLY: begin
          status_r <= apply_st;
          if (apply_st == obue_pkg::ST_OK) begin
            res_valid_r[side_r] <= 1'b1;
            res_price_r[side_r] <= rprice_r;
            res_size_r[side_r]  <= apply_slot.size;
          end
          if (side_r || apply_st != obue_pkg::ST_OK) begin
            state_r <= S_DONE;
          end else begin
            side_r  <= 1'b1;
            state_r <= S_SIDE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            if (!cmd_r.is_load && status_r == obue_pkg::ST_OK) begin
              last_seq_r <= cmd_r.seq;
            end
            out_valid_r                 <= 1'b1;
            out_data_r.status           <= status_r;
            out_data_r.out_sequence     <= cmd_r.seq;
            out_data_r.bid_valid        <= res_valid_r[0];
            out_data_r.bid_out_order_id <= res_valid_r[0] ? cmd_r.sd[0].oid : '0;
            out_data_r.bid_out_price    <= res_price_r[0];
            out_data_r.bid_out_size     <= res_size_r[0];
            out_data_r.ask_valid        <= res_valid_r[1];
            out_data_r.ask_out_order_id <= res_valid_r[1] ? cmd_r.sd[1].oid : '0;
            out_data_r.ask_out_price    <= res_price_r[1];
            out_data_r.ask_out_size     <= res_size_r[1];
            state_r                     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/order_book_update_engine_core.sv
// Top level of the order book update engine.
// Depends on obue_pkg, obue_front, obue_queue and obue_back.
//
// Usage:
// - Input channel in_valid/in_stall/in_data carries one request: a snapshot
//   load (sides written verbatim, sequence set) or a sequenced update with an
//   optional bid and an optional ask change.
// - Output channel out_valid/out_stall/out_data returns exactly one result per
//   request, in request order, with status and the resolved entries.
// - A request is taken when valid is high and stall is low on that channel.
// - Each present side costs one full scan of the BOOK_DEPTH slot table,
//   plus a second scan when the price is zero and must be looked up, plus
//   a setup and a write step. Stale or gap results skip the scans; the
//   engine works on one request at a time, and the slot RAM has one read
//   port, so each scan reads the slots in turn.
// - A two-entry command queue accepts new requests while the engine works
//   or while a result waits in the output register.
// - After reset the engine clears all BOOK_DEPTH slots of the table;
//   requests queue up meanwhile and are served afterwards.
// - When the receiver stalls, the result holds, the engine waits, and the
//   input stalls once the queue is full.
module order_book_update_engine_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  obue_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output obue_pkg::out_item_t out_data
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_nonempty;
  obue_pkg::cmd_t push_cmd;
  obue_pkg::cmd_t pop_cmd;

  obue_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_cmd    (push_cmd)
  );

  obue_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_cmd  (pop_cmd)
  );

  obue_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### rtl/obue_checker.sv
// Port-level checker for the order book update engine, bound to the top level.
// Depends on obue_pkg and assert_macros.svh.
`include "assert_macros.svh"

module obue_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input obue_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input obue_pkg::out_item_t out_data
);

  `AST_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `AST_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `AST_IMPL(a_seq_fail_empty, out_valid && (out_data.status == obue_pkg::ST_STALE || out_data.status == obue_pkg::ST_GAP), !out_data.bid_valid && !out_data.ask_valid, "sequence failure reports a side")
  `AST_IMPL(a_bid_zero, out_valid && !out_data.bid_valid, out_data.bid_out_order_id == '0 && out_data.bid_out_price == '0 && out_data.bid_out_size == '0, "unreported bid not zero")

endmodule

bind order_book_update_engine_core obue_checker u_obue_checker (.*);
